[rtl/row_argmax_argmin_nan_aware_macros.svh]
// Assertion macros shared by the row arg-max / arg-min block.
`ifndef ROW_ARGMAX_ARGMIN_NAN_AWARE_MACROS_SVH
`define ROW_ARGMAX_ARGMIN_NAN_AWARE_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define RAM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define RAM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// Next-cycle implication that is also checked across reset.
`define RAM_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[rtl/ram_pkg.sv]
// Package with types, constants and compare functions of the row arg-max block.
`default_nettype none
package ram_pkg;
   localparam longint MAX_COLS = 65536;
   localparam logic [15:0] COL_CAP = (MAX_COLS - 1 > 65535) ? 16'hFFFF : 16'(MAX_COLS - 1);

   typedef enum logic [1:0] {
      REG_ORDER_MODE    = 2'd0,
      REG_NUMBER_FORMAT = 2'd1,
      REG_MERGE_ENABLE  = 2'd2
   } reg_index_type;

   // Keeps only the bits that the current format uses.
   function automatic logic [31:0] fmt_bits(input logic [31:0] raw, input logic single);
      fmt_bits = single ? raw : {16'h0000, raw[15:0]};
   endfunction

   function automatic logic is_nan(input logic [31:0] b, input logic single);
      if (single) begin
         is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      end else begin
         is_nan = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
      end
   endfunction

   // True when a is strictly greater than b; neither may be NaN.
   // Both formats order like sign-magnitude integers, and the two zeros are equal.
   function automatic logic greater(input logic [31:0] a, input logic [31:0] b,
                                    input logic single);
      logic        sa;
      logic        sb;
      logic [30:0] ma;
      logic [30:0] mb;
      sa = single ? a[31] : a[15];
      sb = single ? b[31] : b[15];
      ma = single ? a[30:0] : {16'h0000, a[14:0]};
      mb = single ? b[30:0] : {16'h0000, b[14:0]};
      unique case ({sa, sb})
         2'b00:   greater = ma > mb;
         2'b11:   greater = ma < mb;
         2'b01:   greater = (ma != 31'd0) || (mb != 31'd0);
         default: greater = 1'b0;
      endcase
   endfunction

   function automatic logic better(input logic [31:0] a, input logic [31:0] b,
                                   input logic single, input logic minimum);
      better = minimum ? greater(b, a, single) : greater(a, b, single);
   endfunction
endpackage
`default_nettype wire

[rtl/row_argmax_argmin_nan_aware.sv]
// Top level of the row arg-max / arg-min reduction with NaN propagation.
//
//  channel  direction  transfer when           payload
//  req      in         req_tvalid & tready     tdata, tlast = last element of row
//  rsp      out        rsp_tvalid & tready     tdata = value, index
//  csr      in         csr_valid & csr_ready   csr_index, csr_data[0]
//
// One element is taken each unstalled cycle; the kept value, index and column
// count update in the cycle of the transfer, and a row result is registered with
// its last element. A waiting result stalls input only while rsp_tready is low.
// Synchronous reset clears the registers, the row state and the result valid.
`default_nettype none
`include "row_argmax_argmin_nan_aware_macros.svh"
module row_argmax_argmin_nan_aware (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] element_value, [63:32] prior_value, [79:64] prior_index
   input  wire logic [79:0] req_tdata,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] result_value, [47:32] result_index
   output logic [47:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   logic        order_mode_ff, number_format_ff, merge_enable_ff;
   logic [31:0] best_value_ff, best_value_in;
   logic [15:0] best_index_ff, best_index_in;
   logic [15:0] column_count_ff, column_count_in;
   logic        row_started_ff, row_started_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic [15:0] rsp_index_ff, rsp_index_in;
   logic        req_xfer;
   logic [31:0] elem, kept, prior;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_index_ff, rsp_value_ff};

   always_comb begin
      elem  = ram_pkg::fmt_bits(req_tdata[31:0], number_format_ff);
      prior = ram_pkg::fmt_bits(req_tdata[63:32], number_format_ff);
      kept  = ram_pkg::fmt_bits(best_value_ff, number_format_ff);
      best_value_in   = best_value_ff;
      best_index_in   = best_index_ff;
      column_count_in = column_count_ff;
      row_started_in  = row_started_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_value_in    = rsp_value_ff;
      rsp_index_in    = rsp_index_ff;
      if (req_xfer) begin
         // The kept bits are trimmed to the current format only when an element arrives.
         best_value_in = kept;
         if (!row_started_ff) begin
            best_value_in   = elem;
            best_index_in   = 16'd0;
            column_count_in = 16'd0;
         end else if (!ram_pkg::is_nan(kept, number_format_ff) &&
                      (ram_pkg::is_nan(elem, number_format_ff) ||
                       ram_pkg::better(elem, kept, number_format_ff, order_mode_ff))) begin
            best_value_in = elem;
            best_index_in = column_count_ff;
         end
         if (column_count_in < ram_pkg::COL_CAP) begin
            column_count_in = column_count_in + 16'd1;
         end
         row_started_in = 1'b1;
         if (req_tlast) begin
            rsp_valid_in = 1'b1;
            rsp_value_in = best_value_in;
            rsp_index_in = best_index_in;
            // The prior wins only against a row result that is not NaN.
            if (merge_enable_ff && !ram_pkg::is_nan(best_value_in, number_format_ff) &&
                (ram_pkg::is_nan(prior, number_format_ff) ||
                 ram_pkg::better(prior, best_value_in, number_format_ff,
                                 order_mode_ff))) begin
               rsp_value_in = prior;
               rsp_index_in = req_tdata[79:64];
            end
            row_started_in  = 1'b0;
            column_count_in = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff    <= 1'b0;
         number_format_ff <= 1'b0;
         merge_enable_ff  <= 1'b0;
         best_value_ff    <= 32'd0;
         best_index_ff    <= 16'd0;
         column_count_ff  <= 16'd0;
         row_started_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               ram_pkg::REG_ORDER_MODE:    order_mode_ff    <= csr_data[0];
               ram_pkg::REG_NUMBER_FORMAT: number_format_ff <= csr_data[0];
               ram_pkg::REG_MERGE_ENABLE:  merge_enable_ff  <= csr_data[0];
               default: ;
            endcase
         end
         best_value_ff   <= best_value_in;
         best_index_ff   <= best_index_in;
         column_count_ff <= column_count_in;
         row_started_ff  <= row_started_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
   end

   `RAM_ASSERT_NEXT(a_last_gives_result, clock, reset, req_xfer && req_tlast, rsp_valid_ff)
   `RAM_ASSERT_NOW(a_idle_count_zero, clock, reset, !row_started_ff, column_count_ff == 16'd0)
   `RAM_ASSERT_NOW(a_half_upper_zero, clock, reset, rsp_valid_ff && !number_format_ff,
      rsp_value_ff[31:16] == 16'd0)
   `RAM_ASSERT_ALWAYS_NEXT(a_reset_clears, clock, reset, !rsp_valid_ff && !row_started_ff)
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the row arg-max / arg-min block with NaN handling.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [15:0] index;
      logic [31:0] value;
   } row_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = ram_pkg::REG_ORDER_MODE;
   logic [31:0] csr_data = '0;

   row_argmax_argmin_nan_aware dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow of the block's registers and row state.
   logic        minimum_mode;
   logic        single_mode;
   logic        merging;
   logic [31:0] kept_value;
   logic [15:0] kept_index;
   logic [15:0] next_column;
   logic        in_row;

   row_result_t pending_results[$];
   int          error_count = 0;
   int          rows_checked = 0;
   int          items_sent;
   int          idle_cycles = 0;
   bit          hold_receiver;
   bit          timed_out = 1'b0;
   int          burst_left;

   function automatic logic [31:0] keep_fmt(input logic [31:0] raw);
      return single_mode ? raw : {16'h0000, raw[15:0]};
   endfunction

   function automatic logic nan_bits(input logic [31:0] b);
      if (single_mode) return (b[30:23] == 8'hFF) && (b[22:0] != 0);
      return (b[14:10] == 5'h1F) && (b[9:0] != 0);
   endfunction

   // Strict order on sign-magnitude bits, both zeros equal.
   function automatic logic exceeds(input logic [31:0] a, input logic [31:0] b);
      logic        sa, sb;
      logic [30:0] ma, mb;
      sa = single_mode ? a[31] : a[15];
      sb = single_mode ? b[31] : b[15];
      ma = single_mode ? a[30:0] : {16'h0, a[14:0]};
      mb = single_mode ? b[30:0] : {16'h0, b[14:0]};
      if (!sa && !sb) return ma > mb;
      if (sa && sb) return ma < mb;
      if (!sa && sb) return (ma != 0) || (mb != 0);
      return 1'b0;
   endfunction

   function automatic logic improves(input logic [31:0] a, input logic [31:0] b);
      return minimum_mode ? exceeds(b, a) : exceeds(a, b);
   endfunction

   task automatic predict_element(input logic [31:0] elem_raw, input logic last,
                                  input logic [31:0] prior_raw, input logic [15:0] prior_idx);
      logic [31:0] elem, kept, pv;
      row_result_t res;
      elem = keep_fmt(elem_raw);
      kept = keep_fmt(kept_value);
      if (!in_row) begin
         kept = elem;
         kept_index = 0;
         next_column = 0;
         in_row = 1'b1;
      end else if (!nan_bits(kept) && (nan_bits(elem) || improves(elem, kept))) begin
         kept = elem;
         kept_index = next_column;
      end
      kept_value = kept;
      if (next_column < ram_pkg::COL_CAP) next_column++;
      if (last) begin
         res.value = kept_value;
         res.index = kept_index;
         if (merging && !nan_bits(res.value)) begin
            pv = keep_fmt(prior_raw);
            if (nan_bits(pv) || improves(pv, res.value)) begin
               res.value = pv;
               res.index = prior_idx;
            end
         end
         pending_results.push_back(res);
         in_row = 1'b0;
         next_column = 0;
      end
   endtask

   // Sends one element, with bursts and random gaps on the sender side.
   // Valid stays high after the transfer; a gap or a drain lowers it.
   task automatic send_element(input logic [31:0] elem, input logic last,
                               input logic [31:0] prior = 0, input logic [15:0] pidx = 0);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {pidx, prior, elem};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_element(elem, last, prior, pidx);
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input ram_pkg::reg_index_type idx, input logic value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= {31'd0, value};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ram_pkg::REG_ORDER_MODE:    minimum_mode = value;
         ram_pkg::REG_NUMBER_FORMAT: single_mode = value;
         default:                    merging = value;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic order, input logic fmt, input logic merge);
      drain_results();
      write_reg(ram_pkg::REG_ORDER_MODE, order);
      write_reg(ram_pkg::REG_NUMBER_FORMAT, fmt);
      write_reg(ram_pkg::REG_MERGE_ENABLE, merge);
   endtask

   // Values biased toward zeros, infinities, NaNs and ties.
   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: v = single_mode ? {v[31], 31'h7F800000 | (v[22:0] | 23'd1)}
                            : {v[31:16], v[15], 15'h7C00 | (v[9:0] | 10'd1)};
         1: v = single_mode ? {v[31], 31'h7F800000} : {v[31:16], v[15], 15'h7C00};
         2: v = single_mode ? {v[31], 31'd0} : {v[31:16], v[15], 15'd0};
         3: v = {v[31:4], 4'h0} & (single_mode ? 32'hC0F0_0000 : 32'hFFFF_C300);
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_row(input int len);
      for (int i = 0; i < len; i++)
         send_element(pick_value(), i == len - 1, pick_value(), 16'($urandom));
   endtask

   task automatic test_directed_half_max();
      configure(1'b0, 1'b0, 1'b0);
      send_element(32'hFFFF_3C00, 1'b1);              // single-element row
      send_element(32'h0000_8000, 1'b0);              // negative zero then positive zero
      send_element(32'h0000_0000, 1'b0);
      send_element(32'h0000_7BFF, 1'b0);
      send_element(32'h0000_7BFF, 1'b1);              // ties keep the first
      send_element(32'h0000_7E00, 1'b0);              // NaN first, then held
      send_element(32'h0000_7C00, 1'b1);
      send_element(32'h0000_FC00, 1'b0);
      send_element(32'h0000_7C01, 1'b0);
      send_element(32'h0000_7C00, 1'b1);
   endtask

   task automatic test_directed_single_min_merge();
      configure(1'b1, 1'b1, 1'b1);
      send_element(32'h7F80_0000, 1'b0);
      send_element(32'hFF80_0000, 1'b1, 32'hFF80_0000, 16'hFFFF);   // equal prior loses
      send_element(32'h0000_0001, 1'b1, 32'h8000_0001, 16'h1234);   // prior better
      send_element(32'h3F80_0000, 1'b1, 32'h7FFF_FFFF, 16'hABCD);   // NaN prior wins
      send_element(32'hFFC0_0000, 1'b1, 32'h0000_0000, 16'h5555);   // NaN row keeps
      configure(1'b0, 1'b0, 1'b1);
      send_element(32'h0000_3C00, 1'b1, 32'hFFFF_4000, 16'h00FF);
      send_element(32'h0000_0001, 1'b0);
      send_element(32'hFFFF_8001, 1'b1, 32'h0000_7C01, 16'h8000);
   endtask

   task automatic test_format_change_mid_row();
      configure(1'b0, 1'b1, 1'b0);
      send_element(32'h4000_3C00, 1'b0);
      drain_results();
      write_reg(ram_pkg::REG_NUMBER_FORMAT, 1'b0);
      write_reg(ram_pkg::REG_ORDER_MODE, 1'b1);
      send_element(32'h0000_3800, 1'b1);
   endtask

   task automatic test_long_row();
      configure(1'b0, 1'b0, 1'b0);
      // Rising values make the last column win; checks index counting.
      for (int i = 0; i < 300; i++)
         send_element(32'(16'h0400 + i), i == 299);
   endtask

   task automatic test_random_rows();
      int base;
      base = items_sent;
      for (int phase = 0; phase < 4; phase++) begin
         configure(1'($urandom), 1'($urandom), 1'($urandom));
         while (items_sent < base + (phase + 1) * 35) begin
            send_row($urandom_range(0, 7) == 0 ? $urandom_range(10, 30)
                                               : $urandom_range(1, 5));
            if ($urandom_range(0, 15) == 0) drain_results();
         end
      end
   endtask

   task automatic test_backpressure();
      configure(1'b1, 1'b0, 1'b1);
      hold_receiver = 1'b1;
      fork
         begin
            repeat (200) @(posedge clock);
            hold_receiver = 1'b0;
         end
         begin
            burst_left = 1000;
            for (int i = 0; i < 40; i++) send_row(1);
         end
      join
   endtask

   // Receiver: own stall pattern, long hold when requested.
   always @(posedge clock) begin
      if (reset || hold_receiver) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 3) != 0) || ((idle_cycles & 8) != 0);
   end

   always @(posedge clock) begin
      row_result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result value %h index %h", $time, got.value, got.index);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            rows_checked++;
            if (got.value !== want.value) begin
               $display("%0t: value expected %h actual %h", $time, want.value, got.value);
               error_count++;
            end
            if (got.index !== want.index) begin
               $display("%0t: index expected %h actual %h", $time, want.index, got.index);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      items_sent = 0;
      burst_left = 0;
      hold_receiver = 1'b0;
      minimum_mode = 1'b0;
      single_mode = 1'b0;
      merging = 1'b0;
      kept_value = '0;
      kept_index = '0;
      next_column = '0;
      in_row = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_half_max();
      test_directed_single_min_merge();
      test_format_change_mid_row();
      test_long_row();
      test_backpressure();
      test_random_rows();
      drain_results();
      repeat (10) @(posedge clock);
      $display("Sent %0d elements and checked %0d row results across max/min,", items_sent,
               rows_checked);
      $display("half/single and merge settings, with long receiver stalls.");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/ram_pkg.sv
rtl/row_argmax_argmin_nan_aware.sv
tb/tb.sv
